// ===== rtl/jac_pkg.sv =====
// Shared types and constants of the joystick axis conditioner.
package jac_pkg;

	localparam int SAMPLE_W       = 12;
	localparam int SUM_W          = 16;
	localparam int POS_W          = 16;
	localparam int DZ_W           = 8;
	localparam int POS_LIMIT      = 150;
	localparam int Q15_MAX        = 32767;
	localparam int WINDOW_DEF     = 5;
	localparam int MEDIAN_POS_DEF = 2;
	localparam int ROUNDS_DEF     = 4;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [DZ_W-1:0] DZ_RESET = 8'd8;

	// position magnitude = floor(q * 32767 / 150), done as q * SCALE_M >> SCALE_SH
	// (exact for q in 0..150)
	localparam int    SCALE_SH = 16;
	localparam int    SCALE_MW = 24;
	localparam longint SCALE_M_L =
		((longint'(Q15_MAX) << SCALE_SH) + longint'(POS_LIMIT) - 1) / longint'(POS_LIMIT);
	localparam logic [SCALE_MW-1:0] SCALE_M = SCALE_MW'(SCALE_M_L);

	// One finished window median on its way from the front to the back.
	typedef struct packed {
		logic [SAMPLE_W-1:0] median;
		logic                axis;
		logic                kind;   // 1: calibration batch
		logic                first;  // first median of a batch, restart the sum
		logic                last;   // completes the batch, produce a result
	} med_req_t;

endpackage

// ===== rtl/jac_front.sv =====
// Front part: takes samples, fills the window, tracks batches and picks the median.
module jac_front import jac_pkg::*; #(
	parameter int WINDOW     = WINDOW_DEF,
	parameter int MEDIAN_POS = MEDIAN_POS_DEF,
	parameter int ROUNDS     = ROUNDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_kind,
	input  logic                in_axis,
	input  logic [SAMPLE_W-1:0] in_sample,
	output logic                push_valid,
	input  logic                push_ready,
	output med_req_t            push_req
);

	localparam int SCW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int RCW  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam int RKW  = $clog2(WINDOW) + 1;
	localparam int RANK = (MEDIAN_POS < WINDOW) ? MEDIAN_POS : WINDOW - 1;

	logic [SAMPLE_W-1:0] win_q [WINDOW];
	logic [SCW-1:0]      cnt_q;
	logic [RCW-1:0]      rnd_q;
	logic                axis_q;
	logic                med_s1;
	logic                axis_s1, kind_s1, first_s1, last_s1;

	logic                accept, changed, win_done, last_med;
	logic [SCW-1:0]      cnt;
	logic [RCW-1:0]      rnd;
	logic [RKW-1:0]      rank_v [WINDOW];
	logic [SAMPLE_W-1:0] median;

	// a pending median must leave before its window can be overwritten
	assign in_ready = !med_s1 || push_ready;
	assign accept   = in_valid && in_ready;

	assign changed  = in_axis != axis_q;
	assign cnt      = changed ? '0 : cnt_q;
	assign rnd      = changed ? '0 : rnd_q;
	assign win_done = cnt == SCW'(WINDOW - 1);
	assign last_med = rnd == RCW'(ROUNDS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rnd_q  <= '0;
			axis_q <= 1'b0;
			med_s1 <= 1'b0;
		end else begin
			if (push_valid && push_ready) begin
				med_s1 <= 1'b0;
			end
			if (accept) begin
				axis_q <= in_axis;
				cnt_q  <= win_done ? '0 : cnt + 1'b1;
				if (win_done) begin
					rnd_q  <= last_med ? '0 : rnd + 1'b1;
					med_s1 <= 1'b1;
				end else begin
					rnd_q  <= rnd;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && win_done) begin
			axis_s1  <= in_axis;
			kind_s1  <= in_kind;
			first_s1 <= rnd == '0;
			last_s1  <= last_med;
		end
		for (int k = 0; k < WINDOW; k++) begin
			if (accept && cnt == SCW'(k)) begin
				win_q[k] <= in_sample;
			end
		end
	end

	// rank of each entry: smaller entries, plus equal ones further down
	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW; i++) begin
			rank_v[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if (j != i && (win_q[j] < win_q[i] || (j < i && win_q[j] == win_q[i]))) begin
					rank_v[i] = rank_v[i] + 1'b1;
				end
			end
			if (rank_v[i] == RKW'(RANK)) begin
				median = median | win_q[i];
			end
		end
	end

	assign push_valid      = med_s1;
	assign push_req.median = median;
	assign push_req.axis   = axis_s1;
	assign push_req.kind   = kind_s1;
	assign push_req.first  = first_s1;
	assign push_req.last   = last_s1;

endmodule

// ===== rtl/jac_fifo.sv =====
// Short queue of window medians between the front and the back.
module jac_fifo import jac_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  med_req_t push_req,
	output logic     pop_valid,
	input  logic     pop_ready,
	output med_req_t pop_req
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	med_req_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   count_q;
	logic            push, pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_req    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_req;
		end
	end

endmodule

// ===== rtl/jac_back.sv =====
// Back part: sums medians, stores rest offsets and scales positions.
module jac_back import jac_pkg::*; #(
	parameter int ROUNDS = ROUNDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DZ_W-1:0]  dead_zone,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  med_req_t         pop_req,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_axis,
	output logic [POS_W-1:0] out_position,
	output logic             out_calibrated
);

	localparam int     DIV    = 10 * ROUNDS;
	localparam int     DIV_SH = SUM_W + $clog2(DIV);
	localparam int     DIV_MW = SUM_W + 2;
	localparam longint DIV_M_L = ((longint'(1) << DIV_SH) + longint'(DIV) - 1) / longint'(DIV);
	localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'(DIV_M_L);
	localparam int     MAGW   = POS_W - 1;

	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  offset_q [2];

	logic              s1_valid, s2_valid, s3_valid, out_valid_q;
	logic              s1_rdy, s2_rdy, s3_rdy, out_rdy;
	logic              s1_axis, s1_cal, s1_neg;
	logic [SUM_W-1:0]  s1_mag;
	logic              s2_axis, s2_cal, s2_neg;
	logic [SUM_W-1:0]  s2_qmag;
	logic              s3_axis, s3_cal, s3_neg;
	logic [DZ_W+SCALE_MW-1:0] s3_prod;
	logic              axis_q, cal_q;
	logic [POS_W-1:0]  pos_q;

	logic              pop;
	logic [SUM_W-1:0]  sum_new;
	logic [SUM_W:0]    diff;
	logic [SUM_W+DIV_MW-1:0] quot_prod;
	logic [DZ_W-1:0]   clamped;
	logic [MAGW-1:0]   pmag;

	assign out_rdy   = !out_valid_q || out_ready;
	assign s3_rdy    = !s3_valid || out_rdy;
	assign s2_rdy    = !s2_valid || s3_rdy;
	assign s1_rdy    = !s1_valid || s2_rdy;
	assign pop_ready = s1_rdy;
	assign pop       = pop_valid && pop_ready;

	assign sum_new   = (pop_req.first ? '0 : sum_q) + SUM_W'(pop_req.median);
	assign diff      = {1'b0, offset_q[pop_req.axis]} - {1'b0, sum_new};
	assign quot_prod = s1_mag * DIV_M;

	always_comb begin
		if (s2_qmag < SUM_W'(dead_zone)) begin
			clamped = '0;
		end else if (s2_qmag > SUM_W'(POS_LIMIT)) begin
			clamped = DZ_W'(POS_LIMIT);
		end else begin
			clamped = s2_qmag[DZ_W-1:0];
		end
	end

	assign pmag = MAGW'(s3_prod >> SCALE_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			offset_q[0] <= '0;
			offset_q[1] <= '0;
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			s3_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				sum_q <= sum_new;
				if (pop_req.last && pop_req.kind) begin
					offset_q[pop_req.axis] <= sum_new;
				end
			end
			if (s1_rdy) begin
				s1_valid <= pop && pop_req.last;
			end
			if (s2_rdy) begin
				s2_valid <= s1_valid;
			end
			if (s3_rdy) begin
				s3_valid <= s2_valid;
			end
			if (out_rdy) begin
				out_valid_q <= s3_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_rdy) begin
			s1_axis <= pop_req.axis;
			s1_cal  <= pop_req.kind;
			s1_neg  <= !pop_req.kind && diff[SUM_W];
			if (pop_req.kind) begin
				s1_mag <= '0;
			end else begin
				s1_mag <= diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
			end
		end
		if (s2_rdy) begin
			s2_axis <= s1_axis;
			s2_cal  <= s1_cal;
			s2_neg  <= s1_neg;
			s2_qmag <= SUM_W'(quot_prod >> DIV_SH);
		end
		if (s3_rdy) begin
			s3_axis <= s2_axis;
			s3_cal  <= s2_cal;
			s3_neg  <= s2_neg;
			s3_prod <= clamped * SCALE_M;
		end
		if (out_rdy) begin
			axis_q <= s3_axis;
			cal_q  <= s3_cal;
			pos_q  <= s3_neg ? -{1'b0, pmag} : {1'b0, pmag};
		end
	end

	assign out_valid      = out_valid_q;
	assign out_axis       = axis_q;
	assign out_position   = pos_q;
	assign out_calibrated = cal_q;

endmodule

// ===== rtl/joystick_axis_conditioner.sv =====
// Top level of the joystick axis conditioner: median, averaging, dead zone, Q1.15 scaling.
//
// Usage:
//   s_axis carries one ADC sample per request: tdata[11:0] is the sample,
//   tuser[0] is the kind (1 = calibration), tuser[1] the axis. Every WINDOW
//   samples of one axis give a median; ROUNDS medians make a batch. The
//   sample that completes a batch yields one request on m_axis: a signed
//   Q1.15 position in tdata, or a stored rest offset (tuser[1] set, position
//   zero). Other samples yield nothing. A change of axis restarts the batch.
//   cfg writes the dead zone; write it only while the block is idle.
// Timing: one sample per cycle sustained while m_axis is not held. The result of
//   the sample that completes its batch passes the median pick, the queue, the sum
//   and offset compare, the divide by 10*ROUNDS and the dead zone and scale to m_axis.
// Reset: counters, sums and offsets go to zero, the dead zone to 8, the
//   median queue and the back pipeline empty. The window store needs no reset.
// Stall: a held m_axis stalls the back pipeline; the median queue keeps
//   taking medians until full, then s_axis drops tready once a median also waits in the front.
module joystick_axis_conditioner import jac_pkg::*; #(
	parameter int WINDOW     = WINDOW_DEF,
	parameter int MEDIAN_POS = MEDIAN_POS_DEF,
	parameter int ROUNDS     = ROUNDS_DEF,
	parameter int QDEPTH     = QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [15:0]     s_axis_tdata,   // [11:0] sample, rest zero
	input  logic [1:0]      s_axis_tuser,   // [0] kind, [1] axis
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [15:0]     m_axis_tdata,   // [15:0] position
	output logic [1:0]      m_axis_tuser,   // [0] out_axis, [1] calibrated
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [DZ_W-1:0] cfg_data        // dead_zone
);

	logic [DZ_W-1:0] dead_zone_q;

	logic     push_valid, push_ready, pop_valid, pop_ready;
	med_req_t push_req, pop_req;

	// the dead zone register takes a write in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= DZ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dead_zone_q <= cfg_data;
		end
	end

	// front: windowing, batch bookkeeping and median selection
	jac_front #(
		.WINDOW     (WINDOW),
		.MEDIAN_POS (MEDIAN_POS),
		.ROUNDS     (ROUNDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_kind    (s_axis_tuser[0]),
		.in_axis    (s_axis_tuser[1]),
		.in_sample  (s_axis_tdata[SAMPLE_W-1:0]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req)
	);

	// hold medians while the back is stalled
	jac_fifo #(
		.DEPTH      (QDEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_req    (pop_req)
	);

	// back: accumulate, calibrate or scale, and drive the result register
	jac_back #(
		.ROUNDS         (ROUNDS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.dead_zone      (dead_zone_q),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_req        (pop_req),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_axis       (m_axis_tuser[0]),
		.out_position   (m_axis_tdata),
		.out_calibrated (m_axis_tuser[1])
	);

endmodule
